// ===== hdl/tsra_pkg.sv =====
// Shared types and constants of the tile sheet raster arranger.
package tsra_pkg;

    // Fixed widths of the configuration registers and the result position fields.
    localparam int TW_REG_W  = 7;
    localparam int TH_REG_W  = 7;
    localparam int TPR_REG_W = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 9;
    localparam int POS_X_W   = 15;
    localparam int POS_Y_W   = 17;
    // Tile column and tile row counters wrap at these widths.
    localparam int TCI_W     = 12;
    localparam int TRI_W     = 17;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TILE_WIDTH    = 3'd0,
        CFG_TILE_HEIGHT   = 3'd1,
        CFG_TILES_PER_ROW = 3'd2,
        CFG_DRAW_BORDER   = 3'd3,
        CFG_FILL_INDEX    = 3'd4
    } t_cfg_index;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_TILE  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    // Events from the sequencer that move the image height bookkeeping.
    typedef struct packed {
        logic tile_done;
        logic clear;
    } t_tile_evt;

endpackage

// ===== hdl/tsra_store.sv =====
// Pixel byte store: one write port and one registered read port.
module tsra_store #(
    parameter int STORE_BYTES = 65536
) (
    input  logic                           i_clk,
    input  logic                           i_wr_en,
    input  logic [$clog2(STORE_BYTES)-1:0] i_wr_addr,
    input  logic [7:0]                     i_wr_data,
    input  logic                           i_rd_en,
    input  logic [$clog2(STORE_BYTES)-1:0] i_rd_addr,
    output logic [7:0]                     o_rd_data
);

    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/tsra_dims.sv =====
// Configuration registers and the image dimension unit with its serial divider.
module tsra_dims
    import tsra_pkg::*;
#(
    parameter int STORE_BYTES       = 65536,
    parameter int MAX_TILE_SIDE     = 64,
    parameter int MAX_TILES_PER_ROW = 256
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_cfg_valid,
    output logic                                          o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]                          i_cfg_index,
    input  logic [CFG_DAT_W-1:0]                          i_cfg_data,
    input  t_tile_evt                                     i_evt,
    input  logic [$clog2(STORE_BYTES+1)-1:0]              i_full_tiles,
    output logic                                          o_busy,
    output logic [$clog2(MAX_TILE_SIDE+1)-1:0]            o_tw,
    output logic [$clog2(MAX_TILE_SIDE+1)-1:0]            o_th,
    output logic [$clog2(MAX_TILES_PER_ROW+1)-1:0]        o_tpr,
    output logic                                          o_border,
    output logic [7:0]                                    o_fill,
    output logic [$clog2(MAX_TILE_SIDE*MAX_TILE_SIDE+1)-1:0] o_tsize,
    output logic [$clog2(MAX_TILES_PER_ROW*(MAX_TILE_SIDE+1)+1)-1:0] o_w,
    output logic [$clog2(STORE_BYTES*(MAX_TILE_SIDE+1)+1)-1:0]       o_h,
    output logic [$clog2(STORE_BYTES+1)-1:0]              o_rows
);

    localparam int FT_W   = $clog2(STORE_BYTES+1);
    localparam int SIDE_W = $clog2(MAX_TILE_SIDE+1);
    localparam int TPR_W  = $clog2(MAX_TILES_PER_ROW+1);
    localparam int TS_W   = $clog2(MAX_TILE_SIDE*MAX_TILE_SIDE+1);
    localparam int W_W    = $clog2(MAX_TILES_PER_ROW*(MAX_TILE_SIDE+1)+1);
    localparam int H_W    = $clog2(STORE_BYTES*(MAX_TILE_SIDE+1)+1);
    localparam int CNT_W  = $clog2(FT_W+1);

    typedef enum logic [4:0] {
        D_INIT   = 5'b00001,
        D_DIV    = 5'b00010,
        D_ROWS   = 5'b00100,
        D_HEIGHT = 5'b01000,
        D_READY  = 5'b10000
    } t_dims_state;

    t_dims_state          r_state, n_state;
    logic [TW_REG_W-1:0]  r_tile_width;
    logic [TH_REG_W-1:0]  r_tile_height;
    logic [TPR_REG_W-1:0] r_tiles_per_row;
    logic                 r_draw_border;
    logic [7:0]           r_fill_index;
    logic [FT_W-1:0]      r_div_q;
    logic [TPR_W-1:0]     r_div_r;
    logic [CNT_W-1:0]     r_div_cnt;
    logic [FT_W-1:0]      r_rows;
    logic [TPR_W-1:0]     r_rem;
    logic [H_W-1:0]       r_h;
    logic [W_W-1:0]       r_w;
    logic [TS_W-1:0]      r_tsize;

    logic [SIDE_W-1:0]    tw_c, th_c;
    logic [TPR_W-1:0]     tpr_c;
    logic                 cfg_accept;
    logic [TPR_W:0]       partial, diff;
    logic                 ge;

    assign o_cfg_ready = 1'b1;
    assign cfg_accept  = i_cfg_valid && o_cfg_ready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_width    <= TW_REG_W'(8);
            r_tile_height   <= TH_REG_W'(8);
            r_tiles_per_row <= TPR_REG_W'(16);
            r_draw_border   <= 1'b0;
            r_fill_index    <= 8'd0;
        end else if (cfg_accept) begin
            unique case (i_cfg_index)
                CFG_TILE_WIDTH:    r_tile_width    <= i_cfg_data[TW_REG_W-1:0];
                CFG_TILE_HEIGHT:   r_tile_height   <= i_cfg_data[TH_REG_W-1:0];
                CFG_TILES_PER_ROW: r_tiles_per_row <= i_cfg_data[TPR_REG_W-1:0];
                CFG_DRAW_BORDER:   r_draw_border   <= i_cfg_data[0];
                CFG_FILL_INDEX:    r_fill_index    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Out-of-range register values are pulled into their legal range.
    always_comb begin
        if (r_tile_width == '0) begin
            tw_c = SIDE_W'(1);
        end else if (32'(r_tile_width) > 32'(MAX_TILE_SIDE)) begin
            tw_c = SIDE_W'(MAX_TILE_SIDE);
        end else begin
            tw_c = SIDE_W'(r_tile_width);
        end
        if (r_tile_height == '0) begin
            th_c = SIDE_W'(1);
        end else if (32'(r_tile_height) > 32'(MAX_TILE_SIDE)) begin
            th_c = SIDE_W'(MAX_TILE_SIDE);
        end else begin
            th_c = SIDE_W'(r_tile_height);
        end
        if (r_tiles_per_row == '0) begin
            tpr_c = TPR_W'(1);
        end else if (32'(r_tiles_per_row) > 32'(MAX_TILES_PER_ROW)) begin
            tpr_c = TPR_W'(MAX_TILES_PER_ROW);
        end else begin
            tpr_c = TPR_W'(r_tiles_per_row);
        end
    end

    // One restoring divide step: full tiles over tiles per row, a bit per cycle.
    always_comb begin
        partial = {r_div_r, r_div_q[FT_W-1]};
        diff    = partial - {1'b0, tpr_c};
        ge      = partial >= {1'b0, tpr_c};
    end

    // Sequencer of the dimension unit.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            D_INIT:   n_state = D_DIV;
            D_DIV:    if (r_div_cnt == CNT_W'(1)) n_state = D_ROWS;
            D_ROWS:   n_state = D_HEIGHT;
            D_HEIGHT: n_state = D_READY;
            D_READY:  n_state = D_READY;
            default:  n_state = D_INIT;
        endcase
        if (cfg_accept) begin
            n_state = D_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Divider registers.
    always_ff @(posedge i_clk) begin
        if (r_state == D_INIT) begin
            r_div_q   <= i_full_tiles;
            r_div_r   <= '0;
            r_div_cnt <= CNT_W'(FT_W);
        end else if (r_state == D_DIV) begin
            r_div_q   <= {r_div_q[FT_W-2:0], ge};
            r_div_r   <= ge ? diff[TPR_W-1:0] : partial[TPR_W-1:0];
            r_div_cnt <= r_div_cnt - CNT_W'(1);
        end
    end

    // Tile row count, its remainder and the image height; kept up to date
    // as tiles complete, cleared when the image is dropped, and rebuilt by the divider after each register write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= '0;
            r_rem  <= '0;
            r_h    <= '0;
        end else if (r_state == D_ROWS) begin
            r_rows <= r_div_q + FT_W'(r_div_r != '0);
            r_rem  <= r_div_r;
        end else if (r_state == D_HEIGHT) begin
            if (r_rows == '0) begin
                r_h <= '0;
            end else begin
                r_h <= H_W'(r_rows) * (H_W'(th_c) + H_W'(r_draw_border))
                       - H_W'(r_draw_border);
            end
        end else if (i_evt.clear) begin
            r_rows <= '0;
            r_rem  <= '0;
            r_h    <= '0;
        end else if (i_evt.tile_done) begin
            if (r_rem == '0) begin
                r_rows <= r_rows + FT_W'(1);
                if (r_rows == '0) begin
                    r_h <= H_W'(th_c);
                end else begin
                    r_h <= r_h + H_W'(th_c) + H_W'(r_draw_border);
                end
            end
            if (32'(r_rem) + 32'd1 >= 32'(tpr_c)) begin
                r_rem <= '0;
            end else begin
                r_rem <= r_rem + TPR_W'(1);
            end
        end
    end

    // Sizes that follow from the registers alone.
    always_ff @(posedge i_clk) begin
        if (r_state == D_ROWS) begin
            r_tsize <= TS_W'(tw_c) * TS_W'(th_c);
            r_w     <= W_W'(tpr_c) * (W_W'(tw_c) + W_W'(r_draw_border))
                       - W_W'(r_draw_border);
        end
    end

    assign o_busy   = (r_state != D_READY);
    assign o_tw     = tw_c;
    assign o_th     = th_c;
    assign o_tpr    = tpr_c;
    assign o_border = r_draw_border;
    assign o_fill   = r_fill_index;
    assign o_tsize  = r_tsize;
    assign o_w      = r_w;
    assign o_h      = r_h;
    assign o_rows   = r_rows;

    // A register write always restarts the dimension unit.
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_accept |=> (r_state == D_INIT))
        else $error("dimension unit did not restart after a register write");

    // The running remainder stays below the tiles per row.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == D_READY) |-> (r_rem < tpr_c))
        else $error("tile row remainder out of range");

    // No tile rows means no image height.
    a_empty_height: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == D_READY && r_rows == '0) |-> (r_h == '0))
        else $error("image height nonzero with no tile rows");

endmodule

// ===== hdl/tsra_core.sv =====
// Load and emit sequencer: counters, address pipeline and output register.
module tsra_core
    import tsra_pkg::*;
#(
    parameter int STORE_BYTES       = 65536,
    parameter int MAX_TILE_SIDE     = 64,
    parameter int MAX_TILES_PER_ROW = 256
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_in_valid,
    output logic                                          o_in_ready,
    input  logic                                          i_kind,
    input  logic [7:0]                                    i_data_byte,
    output logic                                          o_out_valid,
    input  logic                                          i_out_ready,
    output logic [7:0]                                    o_pixel_value,
    output logic [POS_X_W-1:0]                            o_pos_x,
    output logic [POS_Y_W-1:0]                            o_pos_y,
    output logic                                          o_last_pixel,
    output logic [1:0]                                    o_status,
    input  logic                                          i_busy,
    input  logic [$clog2(MAX_TILE_SIDE+1)-1:0]            i_tw,
    input  logic [$clog2(MAX_TILE_SIDE+1)-1:0]            i_th,
    input  logic [$clog2(MAX_TILES_PER_ROW+1)-1:0]        i_tpr,
    input  logic                                          i_border,
    input  logic [7:0]                                    i_fill,
    input  logic [$clog2(MAX_TILE_SIDE*MAX_TILE_SIDE+1)-1:0] i_tsize,
    input  logic [$clog2(MAX_TILES_PER_ROW*(MAX_TILE_SIDE+1)+1)-1:0] i_w,
    input  logic [$clog2(STORE_BYTES*(MAX_TILE_SIDE+1)+1)-1:0]       i_h,
    input  logic [$clog2(STORE_BYTES+1)-1:0]              i_rows,
    output t_tile_evt                                     o_evt,
    output logic [$clog2(STORE_BYTES+1)-1:0]              o_full_tiles,
    output logic                                          o_wr_en,
    output logic [$clog2(STORE_BYTES)-1:0]                o_wr_addr,
    output logic [7:0]                                    o_wr_data,
    output logic                                          o_rd_en,
    output logic [$clog2(STORE_BYTES)-1:0]                o_rd_addr,
    input  logic [7:0]                                    i_rd_data
);

    localparam int AW     = $clog2(STORE_BYTES);
    localparam int FT_W   = $clog2(STORE_BYTES+1);
    localparam int SIDE_W = $clog2(MAX_TILE_SIDE+1);
    localparam int TPR_W  = $clog2(MAX_TILES_PER_ROW+1);
    localparam int TS_W   = $clog2(MAX_TILE_SIDE*MAX_TILE_SIDE+1);
    localparam int TILE_A = TRI_W + TPR_W + 1;
    localparam int TILE_W = (TILE_A > FT_W) ? TILE_A : FT_W;
    localparam int ROW_W  = 2*SIDE_W + 1;
    localparam int PROD_W = FT_W + TS_W;
    localparam int ADDR_W = PROD_W + 1;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL1 = 5'b00010,
        S_MUL2 = 5'b00100,
        S_ADR  = 5'b01000,
        S_RD   = 5'b10000
    } t_core_state;

    // Control state.
    t_core_state         r_state, n_state;
    logic [FT_W-1:0]     r_bytes_loaded, n_bytes_loaded;
    logic [FT_W-1:0]     r_full_tiles, n_full_tiles;
    logic [TS_W-1:0]     r_byte_in_tile, n_byte_in_tile;
    logic                r_overflow, n_overflow;
    logic [POS_X_W-1:0]  r_out_col, n_out_col;
    logic [POS_Y_W-1:0]  r_out_row, n_out_row;
    logic [TCI_W-1:0]    r_tci, n_tci;
    logic [TRI_W-1:0]    r_tri, n_tri;
    logic [SIDE_W-1:0]   r_cit, n_cit;
    logic [SIDE_W-1:0]   r_rit, n_rit;
    logic                r_o_valid;

    // Pipeline payload.
    logic                r_p_err;
    logic [POS_X_W-1:0]  r_p_x;
    logic [POS_Y_W-1:0]  r_p_y;
    logic                r_p_last;
    t_status             r_p_status;
    logic                r_in_tile;
    logic [SIDE_W-1:0]   r_s_cit, r_s_rit;
    logic [TCI_W-1:0]    r_s_tci;
    logic [TRI_W-1:0]    r_s_tri;
    logic [FT_W-1:0]     r_ft_snap;
    logic [TILE_W-1:0]   r_tile;
    logic [ROW_W-1:0]    r_rowoff;
    logic                r_hit;
    logic [PROD_W-1:0]   r_prod;
    logic                r_hit2;
    logic [7:0]          r_o_pixel;
    logic [POS_X_W-1:0]  r_o_x;
    logic [POS_Y_W-1:0]  r_o_y;
    logic                r_o_last;
    t_status             r_o_status;

    logic                accept, emit_ok, no_tile, load_out;
    logic                col_end, row_end, last, in_tile;
    logic [ADDR_W-1:0]   addr;

    assign o_in_ready = (r_state == S_IDLE) && !i_busy;
    assign accept     = i_in_valid && o_in_ready;
    assign no_tile    = (r_full_tiles == '0);
    assign emit_ok    = accept && i_kind && !no_tile;
    assign load_out   = (r_state == S_RD) && (!r_o_valid || i_out_ready);

    // Position tests for the pixel at the current raster place.
    always_comb begin
        col_end = 32'(r_out_col) + 32'd1 >= 32'(i_w);
        row_end = 32'(r_out_row) + 32'd1 >= 32'(i_h);
        last    = col_end && row_end;
        in_tile = (32'(r_cit) < 32'(i_tw)) && (32'(r_rit) < 32'(i_th)) &&
                  (32'(r_tci) < 32'(i_tpr));
    end

    // Next state of the load counters and the raster walk.
    always_comb begin
        n_state        = r_state;
        n_bytes_loaded = r_bytes_loaded;
        n_full_tiles   = r_full_tiles;
        n_byte_in_tile = r_byte_in_tile;
        n_overflow     = r_overflow;
        n_out_col      = r_out_col;
        n_out_row      = r_out_row;
        n_tci          = r_tci;
        n_tri          = r_tri;
        n_cit          = r_cit;
        n_rit          = r_rit;
        o_evt          = '0;
        o_wr_en        = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!i_kind) begin
                        // Load transaction: store the byte unless the store is full.
                        if (32'(r_bytes_loaded) >= 32'(STORE_BYTES)) begin
                            n_overflow = 1'b1;
                        end else begin
                            o_wr_en        = 1'b1;
                            n_bytes_loaded = r_bytes_loaded + FT_W'(1);
                            if (32'(r_byte_in_tile) + 32'd1 >= 32'(i_tsize)) begin
                                n_byte_in_tile  = '0;
                                n_full_tiles    = r_full_tiles + FT_W'(1);
                                o_evt.tile_done = 1'b1;
                            end else begin
                                n_byte_in_tile = r_byte_in_tile + TS_W'(1);
                            end
                        end
                    end else if (no_tile) begin
                        n_state = S_RD;
                    end else begin
                        n_state = S_MUL1;
                        if (last) begin
                            // Final pixel: the image is dropped and loading starts over.
                            n_bytes_loaded = '0;
                            n_full_tiles   = '0;
                            n_byte_in_tile = '0;
                            n_overflow     = 1'b0;
                            n_out_col      = '0;
                            n_out_row      = '0;
                            n_tci          = '0;
                            n_tri          = '0;
                            n_cit          = '0;
                            n_rit          = '0;
                            o_evt.clear    = 1'b1;
                        end else if (col_end) begin
                            // End of a raster line: step down one pixel row.
                            n_out_col = '0;
                            n_cit     = '0;
                            n_tci     = '0;
                            if (32'(r_rit) + 32'd1 < 32'(i_th)) begin
                                n_rit = r_rit + SIDE_W'(1);
                            end else if (i_border && (32'(r_rit) + 32'd1 == 32'(i_th)) &&
                                         (32'(r_tri) + 32'd1 < 32'(i_rows))) begin
                                n_rit = i_th;
                            end else begin
                                n_rit = '0;
                                n_tri = r_tri + TRI_W'(1);
                            end
                            n_out_row = r_out_row + POS_Y_W'(1);
                        end else begin
                            // Step right one pixel, through a border column if any.
                            if (32'(r_cit) + 32'd1 < 32'(i_tw)) begin
                                n_cit = r_cit + SIDE_W'(1);
                            end else if (i_border && (32'(r_cit) + 32'd1 == 32'(i_tw)) &&
                                         (32'(r_tci) + 32'd1 < 32'(i_tpr))) begin
                                n_cit = i_tw;
                            end else begin
                                n_cit = '0;
                                n_tci = r_tci + TCI_W'(1);
                            end
                            n_out_col = r_out_col + POS_X_W'(1);
                        end
                    end
                end
            end
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_ADR;
            S_ADR:   n_state = S_RD;
            S_RD:    if (!r_o_valid || i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_bytes_loaded <= '0;
            r_full_tiles   <= '0;
            r_byte_in_tile <= '0;
            r_overflow     <= 1'b0;
            r_out_col      <= '0;
            r_out_row      <= '0;
            r_tci          <= '0;
            r_tri          <= '0;
            r_cit          <= '0;
            r_rit          <= '0;
        end else begin
            r_state        <= n_state;
            r_bytes_loaded <= n_bytes_loaded;
            r_full_tiles   <= n_full_tiles;
            r_byte_in_tile <= n_byte_in_tile;
            r_overflow     <= n_overflow;
            r_out_col      <= n_out_col;
            r_out_row      <= n_out_row;
            r_tci          <= n_tci;
            r_tri          <= n_tri;
            r_cit          <= n_cit;
            r_rit          <= n_rit;
        end
    end

    // Capture the request: position, flags and the tile place before it moves on.
    always_ff @(posedge i_clk) begin
        if (accept && i_kind) begin
            r_p_err    <= no_tile;
            r_p_x      <= no_tile ? '0 : r_out_col;
            r_p_y      <= no_tile ? '0 : r_out_row;
            r_p_last   <= no_tile || last;
            r_p_status <= no_tile ? ST_NO_TILE : (r_overflow ? ST_OVERFLOW : ST_OK);
            r_in_tile  <= in_tile;
            r_s_cit    <= r_cit;
            r_s_rit    <= r_rit;
            r_s_tci    <= r_tci;
            r_s_tri    <= r_tri;
            r_ft_snap  <= r_full_tiles;
        end
    end

    // Address pipeline: tile number, tile base, then the byte address.
    always_ff @(posedge i_clk) begin
        if (r_state == S_MUL1) begin
            r_tile   <= TILE_W'(r_s_tri) * TILE_W'(i_tpr) + TILE_W'(r_s_tci);
            r_rowoff <= ROW_W'(r_s_rit) * ROW_W'(i_tw) + ROW_W'(r_s_cit);
        end
        if (r_state == S_MUL2) begin
            r_hit  <= r_in_tile && (r_tile < TILE_W'(r_ft_snap));
            r_prod <= PROD_W'(r_tile[FT_W-1:0]) * PROD_W'(i_tsize);
        end
        if (r_state == S_ADR) begin
            r_hit2 <= r_hit && (addr < ADDR_W'(STORE_BYTES));
        end
    end

    assign addr      = ADDR_W'(r_prod) + ADDR_W'(r_rowoff);
    assign o_rd_en   = (r_state == S_ADR);
    assign o_rd_addr = addr[AW-1:0];
    assign o_wr_addr = r_bytes_loaded[AW-1:0];
    assign o_wr_data = i_data_byte;

    // Output register; it takes a new result as soon as the old one leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_pixel  <= r_p_err ? 8'd0 : (r_hit2 ? i_rd_data : i_fill);
            r_o_x      <= r_p_x;
            r_o_y      <= r_p_y;
            r_o_last   <= r_p_last;
            r_o_status <= r_p_status;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_pixel_value = r_o_pixel;
    assign o_pos_x       = r_o_x;
    assign o_pos_y       = r_o_y;
    assign o_last_pixel  = r_o_last;
    assign o_status      = r_o_status;
    assign o_full_tiles  = r_full_tiles;

    // Every full tile took at least one stored byte.
    a_tiles_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full_tiles <= r_bytes_loaded)
        else $error("more full tiles than loaded bytes");

    // The store is never written and read in the same cycle.
    a_port_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_wr_en && o_rd_en))
        else $error("store write and read collide");

    // A byte offered to a full store raises the overflow flag.
    a_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_kind && (32'(r_bytes_loaded) >= 32'(STORE_BYTES))) |=> r_overflow)
        else $error("overflow not recorded");

endmodule

// ===== hdl/tile_sheet_raster_arranger_unit.sv =====
// Top level of the tile sheet raster arranger.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+--------------------------------------
//   in      | input     | i_in_valid / o_in_ready | i_kind, i_data_byte
//   out     | output    | o_out_valid/i_out_ready | o_pixel_value, o_pos_x, o_pos_y,
//           |           |                         | o_last_pixel, o_status
//   cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// A load transaction makes one write to the pixel store, none once the store is full.
// An emit transaction passes two multiply stages that form the store address, then
// the store read and its registered data; an error request goes straight to output.
// After reset and after every register write the dimension unit runs a serial divide
// of full tiles by tiles per row, with input ready low; register writes are taken in
// every cycle.
// A waiting result in the output register holds the next emit and any input after it.
module tile_sheet_raster_arranger_unit
    import tsra_pkg::*;
#(
    parameter int STORE_BYTES       = 65536,
    parameter int MAX_TILE_SIDE     = 64,
    parameter int MAX_TILES_PER_ROW = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_kind,
    input  logic [7:0]           i_data_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_pixel_value,
    output logic [POS_X_W-1:0]   o_pos_x,
    output logic [POS_Y_W-1:0]   o_pos_y,
    output logic                 o_last_pixel,
    output logic [1:0]           o_status,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int AW     = $clog2(STORE_BYTES);
    localparam int FT_W   = $clog2(STORE_BYTES+1);
    localparam int SIDE_W = $clog2(MAX_TILE_SIDE+1);
    localparam int TPR_W  = $clog2(MAX_TILES_PER_ROW+1);
    localparam int TS_W   = $clog2(MAX_TILE_SIDE*MAX_TILE_SIDE+1);
    localparam int W_W    = $clog2(MAX_TILES_PER_ROW*(MAX_TILE_SIDE+1)+1);
    localparam int H_W    = $clog2(STORE_BYTES*(MAX_TILE_SIDE+1)+1);

    t_tile_evt         evt;
    logic              busy;
    logic [SIDE_W-1:0] tw, th;
    logic [TPR_W-1:0]  tpr;
    logic              border;
    logic [7:0]        fill;
    logic [TS_W-1:0]   tsize;
    logic [W_W-1:0]    w;
    logic [H_W-1:0]    h;
    logic [FT_W-1:0]   rows, full_tiles;
    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [7:0]        wr_data, rd_data;

    // Configuration registers and image dimensions.
    tsra_dims #(
        .STORE_BYTES      (STORE_BYTES),
        .MAX_TILE_SIDE    (MAX_TILE_SIDE),
        .MAX_TILES_PER_ROW(MAX_TILES_PER_ROW)
    ) u_dims (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_evt       (evt),
        .i_full_tiles(full_tiles),
        .o_busy      (busy),
        .o_tw        (tw),
        .o_th        (th),
        .o_tpr       (tpr),
        .o_border    (border),
        .o_fill      (fill),
        .o_tsize     (tsize),
        .o_w         (w),
        .o_h         (h),
        .o_rows      (rows)
    );

    // Load and emit sequencer.
    tsra_core #(
        .STORE_BYTES      (STORE_BYTES),
        .MAX_TILE_SIDE    (MAX_TILE_SIDE),
        .MAX_TILES_PER_ROW(MAX_TILES_PER_ROW)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_data_byte  (i_data_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pixel_value(o_pixel_value),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y),
        .o_last_pixel (o_last_pixel),
        .o_status     (o_status),
        .i_busy       (busy),
        .i_tw         (tw),
        .i_th         (th),
        .i_tpr        (tpr),
        .i_border     (border),
        .i_fill       (fill),
        .i_tsize      (tsize),
        .i_w          (w),
        .i_h          (h),
        .i_rows       (rows),
        .o_evt        (evt),
        .o_full_tiles (full_tiles),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data)
    );

    // Pixel byte store.
    tsra_store #(
        .STORE_BYTES(STORE_BYTES)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench of the tile sheet raster arranger: loads tiles, predicts every pixel.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tsra_pkg::*;

    localparam int     STORE_BYTES       = 65536;
    localparam int     MAX_TILE_SIDE     = 64;
    localparam int     MAX_TILES_PER_ROW = 256;
    localparam int     DRAIN_CYCLES      = 8;
    localparam int     HOLD_CYCLES       = 400;
    localparam int     ITEMS_PER_PHASE   = 390;
    localparam longint CYCLE_LIMIT       = 4_000_000;

    typedef enum bit {
        ITEM_LOAD = 1'b0,
        ITEM_EMIT = 1'b1
    } item_kind_e;

    typedef struct {
        logic [7:0]         value;
        logic [POS_X_W-1:0] x;
        logic [POS_Y_W-1:0] y;
        logic               last;
        t_status            status;
    } raster_pixel_t;

    // Tracks the loaded tiles and the raster walk, and holds the pixels still owed.
    class raster_tracker;
        bit [7:0]      store [STORE_BYTES];
        bit [6:0]      width_reg;
        bit [6:0]      height_reg;
        bit [8:0]      per_row_reg;
        bit            border_reg;
        bit [7:0]      fill_reg;
        int            bytes_loaded;
        int            full_tiles;
        int            byte_in_tile;
        bit            overflowed;
        int            out_col;
        int            out_row;
        int            tile_col;
        int            tile_row;
        int            col_in_tile;
        int            row_in_tile;
        raster_pixel_t pending_pixels[$];
        int            failures;
        int            loads_taken;
        int            results_checked;
        int            no_tile_results;
        int            overflow_results;

        function new();
            width_reg        = 8;
            height_reg       = 8;
            per_row_reg      = 16;
            border_reg       = 0;
            fill_reg         = 0;
            failures         = 0;
            loads_taken      = 0;
            results_checked  = 0;
            no_tile_results  = 0;
            overflow_results = 0;
            clear_image();
        endfunction

        function void clear_image();
            bytes_loaded = 0;
            full_tiles   = 0;
            byte_in_tile = 0;
            overflowed   = 0;
            out_col      = 0;
            out_row      = 0;
            tile_col     = 0;
            tile_row     = 0;
            col_in_tile  = 0;
            row_in_tile  = 0;
        endfunction

        // Zero acts as one, anything above the maximum acts as the maximum.
        static function int clamp(int v, int hi);
            if (v == 0) return 1;
            return (v > hi) ? hi : v;
        endfunction

        function void set_reg(t_cfg_index idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                CFG_TILE_WIDTH:    width_reg   = data[6:0];
                CFG_TILE_HEIGHT:   height_reg  = data[6:0];
                CFG_TILES_PER_ROW: per_row_reg = data[8:0];
                CFG_DRAW_BORDER:   border_reg  = data[0];
                CFG_FILL_INDEX:    fill_reg    = data[7:0];
                default: ;
            endcase
        endfunction

        // Applies one accepted transaction; an emit request owes exactly one pixel.
        function void take_item(item_kind_e kind, logic [7:0] data);
            int            tw;
            int            th;
            int            tpr;
            int            b;
            int            tsize;
            int            rows_t;
            int            w;
            int            h;
            longint        tile;
            longint        addr;
            bit            row_end;
            bit            last;
            raster_pixel_t px;
            tw    = clamp(width_reg, MAX_TILE_SIDE);
            th    = clamp(height_reg, MAX_TILE_SIDE);
            tpr   = clamp(per_row_reg, MAX_TILES_PER_ROW);
            b     = border_reg;
            tsize = tw * th;

            // A load fills the store, or only marks the overflow once it is full.
            if (kind == ITEM_LOAD) begin
                loads_taken++;
                if (bytes_loaded >= STORE_BYTES) begin
                    overflowed = 1;
                end else begin
                    store[bytes_loaded] = data;
                    bytes_loaded++;
                    byte_in_tile++;
                    if (byte_in_tile >= tsize) begin
                        byte_in_tile = 0;
                        full_tiles++;
                    end
                end
                return;
            end

            // Without a complete tile the request is refused and nothing moves.
            if (full_tiles == 0) begin
                px = '{value: 8'd0, x: '0, y: '0, last: 1'b1, status: ST_NO_TILE};
                pending_pixels.push_back(px);
                return;
            end

            rows_t = (full_tiles + tpr - 1) / tpr;
            w      = tpr * tw + b * (tpr - 1);
            h      = rows_t * th + b * (rows_t - 1);

            // Border lines, places past the row and missing tiles show the fill value.
            px.value = fill_reg;
            if (col_in_tile < tw && row_in_tile < th && tile_col < tpr) begin
                tile = longint'(tile_row) * tpr + tile_col;
                if (tile < full_tiles) begin
                    addr = tile * tsize + row_in_tile * tw + col_in_tile;
                    if (addr < STORE_BYTES) px.value = store[addr];
                end
            end
            px.x      = POS_X_W'(out_col);
            px.y      = POS_Y_W'(out_row);
            px.status = overflowed ? ST_OVERFLOW : ST_OK;
            row_end   = (out_col + 1 >= w);
            last      = row_end && (out_row + 1 >= h);
            px.last   = last;
            pending_pixels.push_back(px);

            // Advance the raster walk; a border line sits at the tile side index.
            if (last) begin
                clear_image();
            end else if (row_end) begin
                out_col     = 0;
                col_in_tile = 0;
                tile_col    = 0;
                if (row_in_tile + 1 < th) begin
                    row_in_tile++;
                end else if (b && row_in_tile + 1 == th && tile_row + 1 < rows_t) begin
                    row_in_tile = th;
                end else begin
                    row_in_tile = 0;
                    tile_row    = (tile_row + 1) % (1 << TRI_W);
                end
                out_row = (out_row + 1) % (1 << POS_Y_W);
            end else begin
                if (col_in_tile + 1 < tw) begin
                    col_in_tile++;
                end else if (b && col_in_tile + 1 == tw && tile_col + 1 < tpr) begin
                    col_in_tile = tw;
                end else begin
                    col_in_tile = 0;
                    tile_col    = (tile_col + 1) % (1 << TCI_W);
                end
                out_col = (out_col + 1) % (1 << POS_X_W);
            end
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
                failures++;
            end
        endfunction

        // Compares one accepted result with the oldest pixel owed.
        function void check_pixel(logic [7:0] value, logic [POS_X_W-1:0] x,
                                  logic [POS_Y_W-1:0] y, logic last, logic [1:0] status);
            raster_pixel_t want;
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual value %0d at (%0d, %0d)",
                         $time, value, x, y);
                failures++;
                return;
            end
            want = pending_pixels.pop_front();
            results_checked++;
            if (want.status == ST_NO_TILE) no_tile_results++;
            if (want.status == ST_OVERFLOW) overflow_results++;
            compare_field("pixel_value", want.value, value);
            compare_field("pos_x", want.x, x);
            compare_field("pos_y", want.y, y);
            compare_field("last_pixel", want.last, last);
            compare_field("status", want.status, status);
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_kind = 1'b0;
    logic [7:0]           i_data_byte = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [7:0]           o_pixel_value;
    logic [POS_X_W-1:0]   o_pos_x;
    logic [POS_Y_W-1:0]   o_pos_y;
    logic                 o_last_pixel;
    logic [1:0]           o_status;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_TILE_WIDTH;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    raster_tracker book;
    int            sender_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            hold_requests = 0;
    int            hold_served = 0;
    int            hold_left = 0;
    int            items_sent = 0;
    int            cfg_writes = 0;
    longint        cycle_count = 0;

    tile_sheet_raster_arranger_unit #(
        .STORE_BYTES(STORE_BYTES),
        .MAX_TILE_SIDE(MAX_TILE_SIDE),
        .MAX_TILES_PER_ROW(MAX_TILES_PER_ROW)
    ) dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Every result transaction is checked against the oldest pixel owed.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready) begin
            book.check_pixel(o_pixel_value, o_pos_x, o_pos_y, o_last_pixel, o_status);
        end
    end

    // Watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_item(item_kind_e kind, logic [7:0] data);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_data_byte <= data;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        book.take_item(kind, data);
        items_sent++;
    endtask

    task automatic load_byte();
        send_item(ITEM_LOAD, 8'($urandom_range(0, 255)));
    endtask

    task automatic emit_pixel();
        send_item(ITEM_EMIT, 8'($urandom_range(0, 255)));
    endtask

    // Waits until every owed pixel has arrived and the block has settled.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (book.pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        book.set_reg(idx, data);
        cfg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Tile sides change only while the image is empty, so no unwritten byte is read.
    task automatic set_geometry(logic [CFG_DAT_W-1:0] tw, logic [CFG_DAT_W-1:0] th,
                                logic [CFG_DAT_W-1:0] tpr, logic [CFG_DAT_W-1:0] border,
                                logic [CFG_DAT_W-1:0] fill);
        drain();
        write_reg(CFG_TILE_WIDTH, tw);
        write_reg(CFG_TILE_HEIGHT, th);
        write_reg(CFG_TILES_PER_ROW, tpr);
        write_reg(CFG_DRAW_BORDER, border);
        write_reg(CFG_FILL_INDEX, fill);
    endtask

    // Mid-load or mid-image change of the layout registers that keep tile size.
    task automatic retune();
        drain();
        if ($urandom_range(0, 1)) write_reg(CFG_TILES_PER_ROW, $urandom_range(0, 6));
        if ($urandom_range(0, 1)) write_reg(CFG_DRAW_BORDER, $urandom_range(0, 1));
        write_reg(CFG_FILL_INDEX, $urandom_range(0, 255));
    endtask

    // Completes a tile if none is whole yet, then emits until the image is done.
    task automatic finish_image();
        while (book.bytes_loaded != 0 && book.full_tiles == 0) load_byte();
        while (book.full_tiles != 0) emit_pixel();
    endtask

    // One image of random shape and content, with stray requests and layout changes.
    task automatic random_image();
        int shape;
        int tw;
        int th;
        int tpr;
        int tiles;
        int tsize;
        int n_loads;
        int retune_at;
        int step;
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
            tw    = $urandom_range(9, 127);
            th    = $urandom_range(0, 2);
            tpr   = $urandom_range(0, 2);
            tiles = $urandom_range(1, 2);
        end else if (shape == 1) begin
            tw    = $urandom_range(0, 2);
            th    = $urandom_range(9, 127);
            tpr   = $urandom_range(0, 2);
            tiles = $urandom_range(1, 2);
        end else begin
            tw    = $urandom_range(0, 4);
            th    = $urandom_range(0, 4);
            tpr   = $urandom_range(0, 6);
            tiles = $urandom_range(1, 6);
        end
        set_geometry(tw, th, tpr, $urandom_range(0, 1), $urandom_range(0, 255));
        tsize = raster_tracker::clamp(tw, MAX_TILE_SIDE) *
                raster_tracker::clamp(th, MAX_TILE_SIDE);
        n_loads = tiles * tsize;
        if ($urandom_range(0, 2) == 0) n_loads += $urandom_range(0, tsize - 1);
        retune_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2 * n_loads) : -1;
        step = 0;

        // Loading, with the odd early request mixed in.
        for (int i = 0; i < n_loads; i++) begin
            if (step == retune_at) retune();
            if ($urandom_range(0, 19) == 0) emit_pixel();
            load_byte();
            step++;
        end
        while (book.full_tiles != 0) begin
            if (step == retune_at) retune();
            emit_pixel();
            step++;
        end
        finish_image();
        if ($urandom_range(0, 9) == 0) emit_pixel();
    endtask

    task automatic random_phase(int idle_pct, int stall_pct);
        int first;
        drain();
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        first = items_sent;
        while (items_sent - first < ITEMS_PER_PHASE) random_image();
    endtask

    initial begin
        book = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Request with nothing loaded.
        emit_pixel();

        // One-pixel tiles, width written with upper bits set, border and empty place.
        set_geometry(9'h180, 9'd1, 9'd2, 9'd1, 9'hFF);
        send_item(ITEM_LOAD, 8'h00);
        send_item(ITEM_LOAD, 8'hFF);
        send_item(ITEM_LOAD, 8'hA5);
        finish_image();

        // Partial tile only gives an error; trailing bytes never show up.
        set_geometry(9'd2, 9'd2, 9'd0, 9'd0, 9'h5A);
        repeat (3) load_byte();
        emit_pixel();
        repeat (3) load_byte();
        finish_image();

        // Widest row with clamped registers, while the receiver holds off.
        set_geometry(9'd100, 9'd1, 9'd300, 9'd1, $urandom_range(0, 255));
        repeat (64 + 5) load_byte();
        hold_requests++;
        finish_image();

        // Fill the store and run past it; the whole image carries the overflow status.
        set_geometry(9'd64, 9'd127, 9'd4, 9'd1, $urandom_range(0, 255));
        repeat (STORE_BYTES + 3) load_byte();
        finish_image();

        random_phase(0, 0);
        random_phase(49, 0);
        random_phase(0, 49);
        random_phase(16, 16);

        drain();
        $display("Run covered %0d loads, %0d results (%0d refused, %0d after overflow), %0d writes.",
                 book.loads_taken, book.results_checked, book.no_tile_results,
                 book.overflow_results, cfg_writes);
        $display("Directed corners, widest row, full store and four handshake mixes were exercised.");
        if (book.failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

// ===== files.f =====
hdl/tsra_pkg.sv
hdl/tsra_store.sv
hdl/tsra_dims.sv
hdl/tsra_core.sv
hdl/tile_sheet_raster_arranger_unit.sv
tb/tb.sv
